### hdl/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg
// Types and constants shared by the border crossing calibrator and its checker.
// ----------------------------------------------------------------------------
package bcc_pkg;

  // Crossing phases
  typedef enum logic [2:0] {
    PH_ENTER = 3'd0,
    PH_SPINL = 3'd1,
    PH_SPINR = 3'd2,
    PH_PASS  = 3'd3,
    PH_EXIT  = 3'd4,
    PH_DONE  = 3'd5
  } bcc_phase_t;

  // Request kinds
  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // Configuration register indexes
  localparam logic CFG_DRIVE_SPEED = 1'b0;
  localparam logic CFG_SPIN_HOLD   = 1'b1;

  // Sensor patterns (left, middle, right)
  localparam logic [2:0] PAT_NONE = 3'b000;
  localparam logic [2:0] PAT_ALL  = 3'b111;
  localparam logic [2:0] PAT_L    = 3'b100;
  localparam logic [2:0] PAT_LM   = 3'b110;
  localparam logic [2:0] PAT_R    = 3'b001;
  localparam logic [2:0] PAT_MR   = 3'b011;

  localparam logic [6:0]  DRIVE_SPEED_RST = 7'd100;
  localparam logic [9:0]  SPIN_HOLD_RST   = 10'd90;
  localparam logic [31:0] HB_RESET        = 32'd850;
  localparam logic [31:0] NO_LINE_MARK    = 32'hFFFF_FFFF;
  localparam logic signed [7:0] SPIN_SLOW_OFS = 8'sd30;
  localparam logic signed [7:0] SPIN_FAST_OFS = 8'sd20;

  typedef struct packed {
    logic        kind;
    logic [2:0]  line_pattern;
    logic [31:0] now_ms;
  } bcc_req_t;

  typedef struct packed {
    logic signed [7:0] left_speed;
    logic signed [7:0] right_speed;
    logic [9:0]        hold_ms;
    logic              done_res;
    logic [31:0]       half_block_ms;
  } bcc_res_t;

endpackage

### hdl/border_crossing_calibrator.sv
// ----------------------------------------------------------------------------
// border_crossing_calibrator
// Steers a line follower across one cell border and calibrates the
// half-block travel time from the measured entry time.
// ----------------------------------------------------------------------------
//  channel | ports                                | handshake
//  --------+--------------------------------------+-------------------------
//  in      | in_valid, in_stall, in_req           | valid high, stall low
//  out     | out_valid, out_stall, out_res        | valid high, stall low
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | valid and ready high
//
//  One request per cycle while in_stall is low; results are registered in order.
//  Phase update, the exit-time compare and the half-block update are all
//  combinational, ahead of the result register.
//  A two-deep output (result register plus skid) keeps in_stall low while a
//  single result waits; in_stall rises only when both are full.
//  Synchronous active-low reset: phase complete, half-block time 850,
//  drive speed 100, spin hold 90. cfg_ready is always high.
// ----------------------------------------------------------------------------
module border_crossing_calibrator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bcc_pkg::bcc_req_t in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output bcc_pkg::bcc_res_t out_res,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data
);
  import bcc_pkg::*;

  // configuration
  logic [6:0] drive_speed_r;
  logic [9:0] spin_hold_r;

  // crossing state
  bcc_phase_t  phase_r, phase_nxt, phase_s;
  logic [31:0] enter_start_r, enter_start_nxt;
  logic [31:0] enter_end_r, enter_end_nxt, enter_end_s;
  logic [31:0] exit_start_r, exit_start_nxt, exit_start_s;
  logic [31:0] hb_r, hb_nxt;

  // output side
  logic     out_v_r, out_v_nxt, skid_v_r, skid_v_nxt;
  bcc_res_t out_r, out_nxt, skid_r, skid_nxt, res;

  logic        accept, out_fire;
  logic        expire;
  logic [31:0] ran, entry, limit, hb_upd;
  logic [33:0] hb_sum;
  logic signed [7:0] d_s, spin_slow, spin_fast;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_v_r;
  assign accept    = in_valid && !skid_v_r;
  assign out_fire  = out_v_r && !out_stall;
  assign out_valid = out_v_r;
  assign out_res   = out_r;

  // motor speeds; low drive speeds simply flip the spin signs
  assign d_s       = $signed({1'b0, drive_speed_r});
  assign spin_slow = SPIN_SLOW_OFS - d_s;   // -(d-30)
  assign spin_fast = d_s - SPIN_FAST_OFS;   // d-20

  // --- step logic ----------------------------------------------------------
  always_comb begin
    // first line seen marks entry end (a tick equal to the mark stays unset)
    enter_end_s = enter_end_r;
    if (in_req.line_pattern != PAT_NONE && enter_end_r == NO_LINE_MARK) begin
      enter_end_s = in_req.now_ms;
    end

    phase_s = phase_r;
    case (in_req.line_pattern) inside
      PAT_NONE: begin
        phase_s = (phase_r == PH_ENTER) ? PH_ENTER : PH_EXIT;
      end
      PAT_ALL: begin
        phase_s = PH_PASS;
      end
      PAT_L, PAT_LM: begin
        if (phase_r == PH_ENTER) phase_s = PH_SPINL;
      end
      PAT_R, PAT_MR: begin
        if (phase_r == PH_ENTER) phase_s = PH_SPINR;
      end
      default: begin
        phase_s = phase_r;
      end
    endcase

    // exit start of zero means not yet taken
    exit_start_s = exit_start_r;
    if (phase_s == PH_EXIT && exit_start_r == '0) begin
      exit_start_s = in_req.now_ms;
    end

    ran    = in_req.now_ms - exit_start_s;
    entry  = enter_end_s - enter_start_r;
    limit  = (hb_r != '0) ? hb_r : entry;
    expire = (phase_s == PH_EXIT) && (ran > limit);

    // floor((entry + 3*old) / 4)
    hb_sum = {2'b00, entry} + {1'b0, hb_r, 1'b0} + {2'b00, hb_r};
    hb_upd = (hb_r == '0) ? entry : hb_sum[33:2];

    phase_nxt       = phase_r;
    enter_start_nxt = enter_start_r;
    enter_end_nxt   = enter_end_r;
    exit_start_nxt  = exit_start_r;
    hb_nxt          = hb_r;

    res.left_speed    = d_s;
    res.right_speed   = d_s;
    res.hold_ms       = '0;
    res.done_res      = 1'b0;
    res.half_block_ms = hb_r;

    if (in_req.kind == KIND_START) begin
      // start (or restart) a run
      phase_nxt       = PH_ENTER;
      enter_start_nxt = in_req.now_ms;
      enter_end_nxt   = NO_LINE_MARK;
      exit_start_nxt  = '0;
    end else if (phase_r == PH_DONE) begin
      // no run open: stop, no change
      res.left_speed  = '0;
      res.right_speed = '0;
    end else begin
      phase_nxt      = phase_s;
      enter_end_nxt  = enter_end_s;
      exit_start_nxt = exit_start_s;
      if (phase_s == PH_SPINL) begin
        res.left_speed  = spin_slow;
        res.right_speed = spin_fast;
        res.hold_ms     = spin_hold_r;
      end else if (phase_s == PH_SPINR) begin
        res.left_speed  = spin_fast;
        res.right_speed = spin_slow;
        res.hold_ms     = spin_hold_r;
      end else if (expire) begin
        phase_nxt         = PH_DONE;
        hb_nxt            = hb_upd;
        res.left_speed    = '0;
        res.right_speed   = '0;
        res.done_res      = 1'b1;
        res.half_block_ms = hb_upd;
      end
    end
  end

  // --- output register plus skid ---------------------------------------------
  always_comb begin
    out_v_nxt  = out_v_r;
    out_nxt    = out_r;
    skid_v_nxt = skid_v_r;
    skid_nxt   = skid_r;
    if (out_fire || !out_v_r) begin
      if (skid_v_r) begin
        out_nxt    = skid_r;
        out_v_nxt  = 1'b1;
        skid_v_nxt = 1'b0;
      end else begin
        out_nxt   = res;
        out_v_nxt = accept;
      end
    end else if (accept) begin
      skid_nxt   = res;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_speed_r <= DRIVE_SPEED_RST;
      spin_hold_r   <= SPIN_HOLD_RST;
      phase_r       <= PH_DONE;
      enter_start_r <= '0;
      enter_end_r   <= NO_LINE_MARK;
      exit_start_r  <= '0;
      hb_r          <= HB_RESET;
      out_v_r       <= 1'b0;
      skid_v_r      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_DRIVE_SPEED: drive_speed_r <= cfg_data[6:0];
          CFG_SPIN_HOLD:   spin_hold_r   <= cfg_data[9:0];
          default:         drive_speed_r <= drive_speed_r;
        endcase
      end
      if (accept) begin
        phase_r       <= phase_nxt;
        enter_start_r <= enter_start_nxt;
        enter_end_r   <= enter_end_nxt;
        exit_start_r  <= exit_start_nxt;
        hb_r          <= hb_nxt;
      end
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

endmodule

### hdl/bcc_checker.sv
// ----------------------------------------------------------------------------
// bcc_checker
// Port-level checks for the border crossing calibrator, bound to the top.
// ----------------------------------------------------------------------------
module bcc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input bcc_pkg::bcc_res_t out_res
);

  // nothing comes out of reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // input backs up only when a result is already waiting
  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  // an accepted request always leaves a result valid next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted request produced no result");

  // completion always stops the motors
  a_done_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.done_res) |->
      (out_res.left_speed == 8'sd0 && out_res.right_speed == 8'sd0 &&
       out_res.hold_ms == 10'd0))
    else $error("completion without stop");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_res)))
    else $error("stalled result changed");

endmodule

bind border_crossing_calibrator bcc_checker u_bcc_checker (.*);

### tb/tb_border_crossing_calibrator.sv
// ----------------------------------------------------------------------------
// tb_border_crossing_calibrator
// Self-checking bench for the border crossing calibrator. Requests are
// predicted in a small scoreboard class that keeps its own copy of the
// crossing phase, the time marks, the half-block time and both registers.
// Every result leaving the block is compared field by field against the
// oldest prediction. Stimulus is a short directed list of corner cases,
// then segments of mostly well-formed crossings with random timing, under
// several register settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_border_crossing_calibrator;
  timeunit 1ns;
  timeprecision 1ps;

  import bcc_pkg::*;

  localparam int CLK_PERIOD      = 8;
  localparam int RESET_CYCLES    = 5;
  localparam int SEG_REQUESTS    = 275;   // six segments, about 1650 requests
  localparam int NUM_SEGMENTS    = 6;
  localparam int HOLD_OFF_CYCLES = 64;    // receiver back-pressure burst
  localparam int IDLE_PERCENT    = 12;
  localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no handshake at all
  localparam int END_SETTLE      = 8;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts the motor command for every accepted request and
  // checks results in order.
  // --------------------------------------------------------------------------
  class motor_cmd_tracker;
    bcc_phase_t  phase;
    logic [31:0] enter_start;
    logic [31:0] enter_end;
    logic [31:0] exit_start;
    logic [31:0] half_block_time;
    logic [6:0]  drive_speed;
    logic [9:0]  spin_hold;
    bcc_res_t    pending_cmds[$];
    int          errors;

    function new();
      phase           = PH_DONE;
      enter_start     = '0;
      enter_end       = NO_LINE_MARK;
      exit_start      = '0;
      half_block_time = HB_RESET;
      drive_speed     = DRIVE_SPEED_RST;
      spin_hold       = SPIN_HOLD_RST;
      errors          = 0;
    endfunction

    function int pending();
      return pending_cmds.size();
    endfunction

    function void write_reg(logic idx, logic [31:0] data);
      if (idx == CFG_DRIVE_SPEED) drive_speed = data[6:0];
      else spin_hold = data[9:0];
    endfunction

    function bcc_res_t next_motor_cmd(bcc_req_t r);
      bcc_res_t    cmd;
      logic [31:0] ran;
      logic [31:0] entry;
      logic [31:0] limit;
      logic [33:0] blend;
      int          d;
      int          slow;
      int          fast;
      d    = int'(drive_speed);
      slow = d - int'(SPIN_SLOW_OFS);
      fast = d - int'(SPIN_FAST_OFS);
      cmd  = '0;
      if (r.kind == KIND_START) begin
        phase       = PH_ENTER;
        enter_start = r.now_ms;
        enter_end   = NO_LINE_MARK;
        exit_start  = '0;
        cmd.left_speed  = 8'(d);
        cmd.right_speed = 8'(d);
      end else if (phase < PH_DONE) begin
        // first line sighting; a sighting at the sentinel tick stays unmarked
        if (r.line_pattern != PAT_NONE && enter_end == NO_LINE_MARK)
          enter_end = r.now_ms;
        case (r.line_pattern)
          PAT_NONE:      if (phase != PH_ENTER) phase = PH_EXIT;
          PAT_ALL:       phase = PH_PASS;
          PAT_L, PAT_LM: if (phase == PH_ENTER) phase = PH_SPINL;
          PAT_R, PAT_MR: if (phase == PH_ENTER) phase = PH_SPINR;
          default:       ;
        endcase
        // exit mark of zero means unset, so an exit at tick zero is retaken
        if (phase == PH_EXIT && exit_start == 0) exit_start = r.now_ms;
        case (phase)
          PH_SPINL: begin
            cmd.left_speed  = 8'(-slow);
            cmd.right_speed = 8'(fast);
            cmd.hold_ms     = spin_hold;
          end
          PH_SPINR: begin
            cmd.left_speed  = 8'(fast);
            cmd.right_speed = 8'(-slow);
            cmd.hold_ms     = spin_hold;
          end
          PH_EXIT: begin
            ran   = r.now_ms - exit_start;
            entry = enter_end - enter_start;
            limit = (half_block_time != 0) ? half_block_time : entry;
            if (ran > limit) begin
              phase        = PH_DONE;
              cmd.done_res = 1'b1;
              if (half_block_time == 0) begin
                half_block_time = entry;
              end else begin
                blend = 34'(entry) + 34'(half_block_time) * 34'd3;
                half_block_time = blend[33:2];
              end
            end else begin
              cmd.left_speed  = 8'(d);
              cmd.right_speed = 8'(d);
            end
          end
          default: begin
            cmd.left_speed  = 8'(d);
            cmd.right_speed = 8'(d);
          end
        endcase
      end
      // samples with no run open leave everything alone and answer stop
      cmd.half_block_ms = half_block_time;
      return cmd;
    endfunction

    function void note_request(bcc_req_t r);
      pending_cmds.push_back(next_motor_cmd(r));
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_command(bcc_res_t got);
      bcc_res_t want;
      if (pending_cmds.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual %0d %0d %0d %0d %0d", $time,
                 got.left_speed, got.right_speed, got.hold_ms, got.done_res,
                 got.half_block_ms);
      end else begin
        want = pending_cmds.pop_front();
        compare_field("left_speed", want.left_speed, got.left_speed);
        compare_field("right_speed", want.right_speed, got.right_speed);
        compare_field("hold_ms", want.hold_ms, got.hold_ms);
        compare_field("done_res", want.done_res, got.done_res);
        compare_field("half_block_ms", want.half_block_ms, got.half_block_ms);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and its signals
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  bcc_req_t    in_req;
  logic        out_valid;
  logic        out_stall;
  bcc_res_t    out_res;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  motor_cmd_tracker cmd_tracker = new();

  int requests_sent = 0;
  int no_progress   = 0;
  bit steady        = 1'b0;   // no idling on either side while set
  bit hold_off_req  = 1'b0;   // asks the receiver for one long stall burst

  border_crossing_calibrator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Monitor: all handshakes are sampled at the rising edge, before any of the
  // edge's updates land. Register writes only happen while idle, so applying
  // them here keeps the prediction in step. The watchdog lives here too.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) cmd_tracker.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) cmd_tracker.note_request(in_req);
      if (out_valid && !out_stall) cmd_tracker.check_command(out_res);
      if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
        no_progress <= 0;
      else
        no_progress <= no_progress + 1;
      if (no_progress >= WATCHDOG_LIMIT) begin
        $display("tb_border_crossing_calibrator: FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, none while steady, plus a long hold-off burst
  // on request so the two-deep output fills and the input backs up.
  // --------------------------------------------------------------------------
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  // Offer one request, maybe after an idle gap; returns at the accepting edge.
  // Each idle cycle continues the gap with the idle odds.
  task automatic offer_request(logic kind, logic [2:0] pat, logic [31:0] now);
    bcc_req_t req;
    req.kind         = kind;
    req.line_pattern = pat;
    req.now_ms       = now;
    if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PERCENT);
    end
    in_req   <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  // Stop sending and let every predicted result come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (cmd_tracker.pending() != 0);
    repeat (2) @(posedge clk);
  endtask

  // Register write; the unused upper data bits carry random junk.
  task automatic write_config(logic idx, logic [9:0] field);
    logic [31:0] data;
    data = $urandom;
    if (idx == CFG_DRIVE_SPEED) data[6:0] = field[6:0];
    else data[9:0] = field;
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [31:0] tick;
    logic [31:0] tick_start;
    logic [31:0] tick_line;
    logic [31:0] tick_exit;
    logic [31:0] hb;
    logic [31:0] limit;
    logic [2:0]  pat;
    logic [6:0]  spd;
    logic [9:0]  hold;
    longint      ran;
    int          seg_end;
    int          runs;
    int          steps;
    bit          zero_entry;

    in_valid  <= 1'b0;
    in_req    <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_DRIVE_SPEED;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed corner cases, reset register values ----
    offer_request(KIND_SAMPLE, PAT_ALL, 32'd0);            // no run open yet
    offer_request(KIND_START, 3'b101, 32'hFFFF_FFF0);      // run near the wrap
    offer_request(KIND_SAMPLE, PAT_NONE, 32'hFFFF_FFF8);
    offer_request(KIND_SAMPLE, PAT_L, 32'hFFFF_FFFF);      // line at sentinel tick
    offer_request(KIND_SAMPLE, PAT_LM, 32'd3);             // mark taken here
    offer_request(KIND_SAMPLE, 3'b010, 32'd5);             // middle only: no change
    offer_request(KIND_SAMPLE, PAT_ALL, 32'd16);
    offer_request(KIND_SAMPLE, PAT_NONE, 32'd0);           // exit at tick zero
    offer_request(KIND_SAMPLE, PAT_NONE, 32'd100);         // exit mark taken
    offer_request(KIND_SAMPLE, PAT_ALL, 32'd500);          // back to passing
    offer_request(KIND_SAMPLE, PAT_NONE, 32'd950);         // elapsed equals limit
    offer_request(KIND_SAMPLE, PAT_R, 32'd951);            // one past: complete
    offer_request(KIND_SAMPLE, 3'b101, 32'd960);           // after completion
    offer_request(KIND_START, PAT_NONE, 32'd1000);
    offer_request(KIND_SAMPLE, PAT_R, 32'd1000);           // zero entry time
    offer_request(KIND_SAMPLE, PAT_MR, 32'd1004);
    offer_request(KIND_START, PAT_ALL, 32'd2000);          // abandon the run
    offer_request(KIND_SAMPLE, PAT_MR, 32'd2005);
    wait_for_results();
    write_config(CFG_DRIVE_SPEED, 10'd0);                  // spin speeds flip sign
    write_config(CFG_SPIN_HOLD, 10'd1023);
    offer_request(KIND_START, PAT_NONE, 32'd3000);
    offer_request(KIND_SAMPLE, PAT_LM, 32'd3001);
    offer_request(KIND_START, PAT_NONE, 32'd3100);
    offer_request(KIND_SAMPLE, PAT_R, 32'd3102);
    wait_for_results();
    write_config(CFG_DRIVE_SPEED, 10'd127);
    write_config(CFG_SPIN_HOLD, 10'd0);
    offer_request(KIND_START, PAT_ALL, 32'hFFFF_FFFF);
    offer_request(KIND_SAMPLE, PAT_L, 32'd5);
    offer_request(KIND_SAMPLE, 3'b101, 32'd6);

    // ---- random segments ----
    // Segment 0 runs with no idling and zero entry times, which walks the
    // half-block time down to zero; segment 1 then starts with the entry
    // time as the limit and carries the receiver hold-off bursts.
    for (int s = 0; s < NUM_SEGMENTS; s++) begin
      wait_for_results();
      case (s)
        0:       begin spd = 7'd127; hold = 10'd1023; end
        1:       begin spd = 7'd0;   hold = 10'd0;    end
        2:       begin spd = 7'd30;  hold = 10'd90;   end
        3:       begin spd = 7'd29;  hold = 10'd512;  end
        default: begin
          spd  = 7'($urandom_range(0, 127));
          hold = 10'($urandom_range(0, 1023));
        end
      endcase
      write_config(CFG_DRIVE_SPEED, {3'b000, spd});
      write_config(CFG_SPIN_HOLD, hold);
      steady     = (s == 0);
      zero_entry = (s == 0);
      if (s == 1) hold_off_req = 1'b1;
      seg_end = requests_sent + SEG_REQUESTS;
      runs    = 0;
      while (requests_sent < seg_end) begin
        // occasional garbage between runs
        if (s != 0 && $urandom_range(0, 7) == 0)
          repeat ($urandom_range(1, 4))
            offer_request($urandom_range(0, 1) ? KIND_SAMPLE : KIND_START,
                          3'($urandom), $urandom);

        tick = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 300)
                                           : $urandom;
        offer_request(KIND_START, 3'($urandom), tick);
        tick_start = tick;
        if (!zero_entry) begin
          repeat ($urandom_range(0, 3)) begin
            tick += $urandom_range(0, 40);
            offer_request(KIND_SAMPLE, PAT_NONE, tick);
          end
          tick += $urandom_range(0, 40);
        end
        offer_request(KIND_SAMPLE, 3'($urandom_range(1, 7)), tick);
        tick_line = tick;
        repeat ($urandom_range(0, 3)) begin
          tick += $urandom_range(0, 60);
          offer_request(KIND_SAMPLE, 3'($urandom_range(1, 7)), tick);
        end

        // one run in ten is cut short by the next start
        if ($urandom_range(0, 9) != 0) begin
          tick += $urandom_range(0, 60);
          offer_request(KIND_SAMPLE, PAT_ALL, tick);
          hb    = cmd_tracker.half_block_time;
          limit = (hb != 0) ? hb : tick_line - tick_start;
          tick += $urandom_range(1, 60);
          offer_request(KIND_SAMPLE, PAT_NONE, tick);
          tick_exit = tick;
          if ($urandom_range(0, 3) == 0) begin
            // land exactly on the limit, then one past it
            offer_request(KIND_SAMPLE, 3'($urandom_range(0, 6)), tick_exit + limit);
            offer_request(KIND_SAMPLE, 3'($urandom_range(0, 6)), tick_exit + limit + 1);
          end else begin
            ran   = 0;
            steps = 0;
            while (ran <= limit && steps < 12) begin
              ran += $urandom_range(1, limit / 3 + 1);
              steps++;
              case ($urandom_range(0, 15))
                0:       pat = PAT_ALL;
                1, 2:    pat = 3'($urandom_range(1, 6));
                default: pat = PAT_NONE;
              endcase
              offer_request(KIND_SAMPLE, pat, tick_exit + 32'(ran));
            end
          end
          // samples after the crossing, which answer stop once the run is complete
          repeat ($urandom_range(0, 2))
            offer_request(KIND_SAMPLE, 3'($urandom), $urandom);
        end
        runs++;
        if (s == 1 && runs == 12) hold_off_req = 1'b1;
      end
    end

    wait_for_results();
    repeat (END_SETTLE) @(posedge clk);
    if (cmd_tracker.errors == 0 && cmd_tracker.pending() == 0) begin
      $display("tb_border_crossing_calibrator: PASS");
    end else begin
      $display("tb_border_crossing_calibrator: FAIL");
    end
    $finish;
  end

endmodule
